### rtl/rpd_pkg.sv
`default_nettype none

package rpd_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CNT_EXT_W  = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;

    localparam logic [CNT_EXT_W-1:0] COUNT_MAX_EXT =
        {{(CNT_EXT_W - COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};
    localparam logic [CNT_EXT_W-1:0] BYTE_COUNT_MAX_EXT =
        {{(CNT_EXT_W - 16){1'b0}}, 16'hFFFF};

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd256;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_BRACE   = 8'h7D;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] CH_UPPER_O = 8'h4F;
    localparam logic [7:0] CH_LOWER_O = 8'h6F;

    localparam logic [4:0] HEX_INVALID = 5'd16;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CK_HIGH = 2'd2,
        PH_CK_LOW  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        MODE_UNDECIDED = 2'd0,
        MODE_PLAIN     = 2'd1,
        MODE_CONSOLE   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [2:0]       mask;
        logic [2:0][7:0]  data;
        logic [15:0]      count;
    } q_entry_t;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = HEX_INVALID;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 5'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 5'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 5'(c - 8'h57);
        end
        return v;
    endfunction

    function automatic logic [3:0] nib(input logic [7:0] c);
        logic [4:0] v;
        v = hex_value(c);
        return v[4] ? 4'hF : v[3:0];
    endfunction

endpackage

`default_nettype wire

### rtl/rpd_front.sv
`default_nettype none

module rpd_front
    import rpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        accept,
    input  wire logic        op,
    input  wire logic [7:0]  rx_byte,
    output logic             push,
    output q_entry_t         entry
);

    phase_t          phase_reg, phase_next;
    mode_t           mode_reg, mode_next;
    logic [7:0]      sum_reg, sum_next;
    logic            esc_reg, esc_next;
    logic [1:0]      pos_reg, pos_next;
    logic [7:0]      held_reg, held_next;
    logic            npend_reg, npend_next;
    logic [3:0]      nhigh_reg, nhigh_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [4:0]      ckh_reg, ckh_next;
    logic [15:0]     max_reg;

    logic [2:0]      cand_v;
    logic [2:0][7:0] cand_b;
    logic            plain_req;
    logic [1:0]      plain_slot;
    logic            clr;
    logic            end_en;
    kind_t           end_kind;
    logic [4:0]      lo;
    logic [1:0]      ncand;
    logic [CNT_EXT_W-1:0] cnt_ext;
    logic [CNT_EXT_W-1:0] max_ext;
    logic [CNT_EXT_W-1:0] cnt_sum;
    logic [CNT_EXT_W-1:0] pre;
    logic [2:0]      emit;

    assign cnt_ext = CNT_EXT_W'(count_reg);
    assign max_ext = CNT_EXT_W'(max_reg);
    assign lo      = hex_value(rx_byte);

    always_comb
    begin
        phase_next = phase_reg;
        mode_next  = mode_reg;
        sum_next   = sum_reg;
        esc_next   = esc_reg;
        pos_next   = pos_reg;
        held_next  = held_reg;
        npend_next = npend_reg;
        nhigh_next = nhigh_reg;
        ckh_next   = ckh_reg;
        cand_v     = 3'b000;
        cand_b     = '0;
        plain_req  = 1'b0;
        plain_slot = 2'd0;
        clr        = 1'b0;
        end_en     = 1'b0;
        end_kind   = KIND_REJECT;
        ncand      = 2'd0;
        cnt_sum    = '0;
        pre        = '0;
        emit       = 3'b000;
        count_next = count_reg;

        if (accept)
        begin
            if (op)
            begin
                phase_next = PH_HUNT;
                clr        = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        if (rx_byte == CH_DOLLAR)
                        begin
                            clr        = 1'b1;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        if (rx_byte == CH_HASH)
                        begin
                            if (mode_reg == MODE_UNDECIDED)
                            begin
                                cand_v[0] = (pos_reg != 2'd0);
                                cand_b[0] = CH_UPPER_O;
                                cand_v[1] = (pos_reg == 2'd2);
                                cand_b[1] = held_reg;
                                pos_next  = 2'd0;
                            end
                            esc_next   = 1'b0;
                            phase_next = PH_CK_HIGH;
                        end
                        else
                        begin
                            sum_next = sum_reg + rx_byte;
                            priority case (mode_reg)
                                MODE_UNDECIDED:
                                begin
                                    priority case (pos_reg)
                                        2'd0:
                                        begin
                                            if (rx_byte == CH_UPPER_O)
                                            begin
                                                pos_next = 2'd1;
                                            end
                                            else
                                            begin
                                                mode_next  = MODE_PLAIN;
                                                plain_req  = 1'b1;
                                                plain_slot = 2'd0;
                                            end
                                        end
                                        2'd1:
                                        begin
                                            if (!lo[4])
                                            begin
                                                held_next = rx_byte;
                                                pos_next  = 2'd2;
                                            end
                                            else
                                            begin
                                                mode_next  = MODE_PLAIN;
                                                pos_next   = 2'd0;
                                                cand_v[0]  = 1'b1;
                                                cand_b[0]  = CH_UPPER_O;
                                                plain_req  = 1'b1;
                                                plain_slot = 2'd1;
                                            end
                                        end
                                        default:
                                        begin
                                            pos_next = 2'd0;
                                            if (!lo[4])
                                            begin
                                                mode_next = MODE_CONSOLE;
                                                cand_v[0] = 1'b1;
                                                cand_b[0] = CH_LOWER_O;
                                                cand_v[1] = 1'b1;
                                                cand_b[1] = {nib(held_reg), lo[3:0]};
                                            end
                                            else
                                            begin
                                                mode_next  = MODE_PLAIN;
                                                cand_v[0]  = 1'b1;
                                                cand_b[0]  = CH_UPPER_O;
                                                cand_v[1]  = 1'b1;
                                                cand_b[1]  = held_reg;
                                                plain_req  = 1'b1;
                                                plain_slot = 2'd2;
                                            end
                                        end
                                    endcase
                                end
                                MODE_CONSOLE:
                                begin
                                    if (npend_reg)
                                    begin
                                        npend_next = 1'b0;
                                        cand_v[0]  = 1'b1;
                                        cand_b[0]  = {nhigh_reg, nib(rx_byte)};
                                    end
                                    else
                                    begin
                                        nhigh_next = nib(rx_byte);
                                        npend_next = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    plain_req  = 1'b1;
                                    plain_slot = 2'd0;
                                end
                            endcase
                        end
                    end
                    PH_CK_HIGH:
                    begin
                        ckh_next   = lo;
                        phase_next = PH_CK_LOW;
                    end
                    default:
                    begin
                        end_en = 1'b1;
                        if (!ckh_reg[4] && !lo[4] && ({ckh_reg[3:0], lo[3:0]} == sum_reg))
                        begin
                            end_kind = KIND_ACCEPT;
                        end
                        phase_next = PH_HUNT;
                        clr        = 1'b1;
                    end
                endcase
            end
        end

        if (plain_req)
        begin
            if (esc_reg)
            begin
                esc_next               = 1'b0;
                cand_v[plain_slot]     = 1'b1;
                cand_b[plain_slot]     = rx_byte ^ ESC_XOR;
            end
            else if (rx_byte == CH_BRACE)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                cand_v[plain_slot] = 1'b1;
                cand_b[plain_slot] = rx_byte;
            end
        end

        for (int i = 0; i < 3; i++)
        begin
            pre     = cnt_ext + CNT_EXT_W'(i);
            emit[i] = cand_v[i] && (pre < max_ext) && (pre < COUNT_MAX_EXT);
        end

        ncand   = 2'(cand_v[0]) + 2'(cand_v[1]) + 2'(cand_v[2]);
        cnt_sum = cnt_ext + CNT_EXT_W'(ncand);
        if (cnt_sum > COUNT_MAX_EXT)
        begin
            cnt_sum = COUNT_MAX_EXT;
        end
        count_next = cnt_sum[COUNT_BITS-1:0];

        if (clr)
        begin
            mode_next  = MODE_UNDECIDED;
            sum_next   = 8'd0;
            esc_next   = 1'b0;
            pos_next   = 2'd0;
            held_next  = 8'd0;
            npend_next = 1'b0;
            nhigh_next = 4'd0;
            ckh_next   = 5'd0;
            count_next = '0;
        end
    end

    always_comb
    begin
        entry = '0;
        push  = 1'b0;
        if (end_en)
        begin
            push        = 1'b1;
            entry.kind  = end_kind;
            entry.mask  = 3'b001;
            entry.count = (cnt_ext >= BYTE_COUNT_MAX_EXT) ? 16'hFFFF : cnt_ext[15:0];
        end
        else
        begin
            push       = (emit != 3'b000);
            entry.kind = KIND_PAYLOAD;
            entry.mask = emit;
            entry.data = cand_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            mode_reg  <= MODE_UNDECIDED;
            sum_reg   <= 8'd0;
            esc_reg   <= 1'b0;
            pos_reg   <= 2'd0;
            held_reg  <= 8'd0;
            npend_reg <= 1'b0;
            nhigh_reg <= 4'd0;
            count_reg <= '0;
            ckh_reg   <= 5'd0;
            max_reg   <= MAX_PAYLOAD_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            sum_reg   <= sum_next;
            esc_reg   <= esc_next;
            pos_reg   <= pos_next;
            held_reg  <= held_next;
            npend_reg <= npend_next;
            nhigh_reg <= nhigh_next;
            count_reg <= count_next;
            ckh_reg   <= ckh_next;
            if (cfg_wr_en)
            begin
                max_reg <= cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/rpd_queue.sv
`default_nettype none

module rpd_queue
    import rpd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  q_entry_t      push_entry,
    input  wire logic     pop,
    output logic          full,
    output logic          not_empty,
    output q_entry_t      head
);

    q_entry_t          mem [Q_DEPTH];
    logic [Q_AW-1:0]   wptr_reg;
    logic [Q_AW-1:0]   rptr_reg;
    logic [Q_AW:0]     fill_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (fill_reg == (Q_AW + 1)'(Q_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/rpd_back.sv
`default_nettype none

module rpd_back
    import rpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        not_empty,
    input  q_entry_t         head,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       data,
    output logic [15:0]      byte_count,
    output logic             last
);

    logic [2:0] done_reg;
    logic [2:0] rem;
    logic [2:0] cur;
    logic       take;

    assign rem       = head.mask & ~done_reg;
    assign cur       = rem & (~rem + 3'd1);
    assign out_valid = not_empty;
    assign last      = ((rem & ~cur) == 3'b000);
    assign take      = out_valid && !out_stall;
    assign pop       = take && last;
    assign kind      = head.kind;
    assign byte_count = head.count;

    always_comb
    begin
        unique case (cur)
            3'b001:  data = head.data[0];
            3'b010:  data = head.data[1];
            3'b100:  data = head.data[2];
            default: data = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 3'b000;
        end
        else if (take)
        begin
            done_reg <= last ? 3'b000 : (done_reg | cur);
        end
    end

    a_word_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rem != 3'b000))
        else $error("Queue head shown with no word left in it.");

    a_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(cur))
        else $error("More than one slot selected for output.");

    a_bundle_held: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last) |=> out_valid)
        else $error("Bundle dropped before its last word was taken.");

endmodule

`default_nettype wire

### rtl/rsp_packet_deframer.sv
// Receive-side packet deframer for a remote serial debug link.
// Input channel (in_valid, in_stall, op, rx_byte) takes one raw byte or a
// clear command per word; a word is taken when in_valid is high and
// in_stall is low. Output channel (out_valid, out_stall, kind, data,
// byte_count, last) gives decoded payload bytes and one accept or reject
// word per packet that reaches its checksum; last marks the final word
// caused by one input word. The front decoder takes one input word per
// cycle unless in_stall is high and hands up to three results as one bundle
// to a four-entry queue; the back end sends one output word per cycle
// unless out_stall is high. Input words flow at one per cycle while each
// causes at most one result; a word causing two or three results keeps its
// bundle at the queue head until all its words are sent. While out_stall
// is high the shown word holds, the queue fills, and once it is full
// in_stall rises. cfg_wr_en/cfg_wr_data write max_payload. Reset empties
// the queue, returns to hunting for a start mark, sets max_payload to 256.
`default_nettype none

module rsp_packet_deframer
    import rpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       data,
    output logic [15:0]      byte_count,
    output logic             last
);

    logic     accept;
    logic     push;
    q_entry_t push_entry;
    logic     q_full;
    logic     q_not_empty;
    q_entry_t q_head;
    logic     pop;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    rpd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .op          (op),
        .rx_byte     (rx_byte),
        .push        (push),
        .entry       (push_entry)
    );

    rpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    rpd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .not_empty  (q_not_empty),
        .head       (q_head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .data       (data),
        .byte_count (byte_count),
        .last       (last)
    );

endmodule

`default_nettype wire
